>>> design/u8c_pkg.sv
// Shared types, constants and decode functions for the UTF-8 line column converter.
// Used by every module of the block; depends on nothing else.
package u8c_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int POS_WIDTH       = 16;
  localparam int TARGET_WIDTH    = 16;
  localparam int BUF_DEPTH       = 4;

  // Line modes: code points to UTF-16 units, and UTF-16 units to code points.
  localparam logic MODE_POINTS = 1'b0;
  localparam logic MODE_UNITS  = 1'b1;

  // Byte class as seen from the lead position.
  typedef enum logic [2:0] {
    LEAD_BAD,
    LEAD_1,
    LEAD_2,
    LEAD_3,
    LEAD_4
  } lead_t;

  typedef struct packed {
    lead_t lead;
    logic  cont;
  } byte_cls_t;

  typedef struct packed {
    logic [7:0] value;
    byte_cls_t  cls;
  } buf_ent_t;

  typedef struct packed {
    logic [7:0]              line_byte;
    logic                    byte_present;
    logic                    last_byte;
    logic                    mode;
    logic [TARGET_WIDTH-1:0] target;
  } in_item_t;

  typedef struct packed {
    logic [POS_WIDTH-1:0] position;
    logic                 saturated;
  } out_item_t;

  typedef struct packed {
    buf_ent_t                ent;
    logic                    byte_present;
    logic                    last_byte;
    logic                    mode;
    logic [TARGET_WIDTH-1:0] target;
  } q_item_t;

  typedef struct packed {
    logic [2:0] used;
    logic       wide;
  } dec_t;

  typedef struct packed {
    logic active;
    logic mid_line;
  } back_status_t;

  function automatic byte_cls_t classify(input logic [7:0] b);
    byte_cls_t c;
    c.cont = ((b & 8'hC0) == 8'h80);
    if (b < 8'h80) begin
      c.lead = LEAD_1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      c.lead = LEAD_2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      c.lead = LEAD_3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      c.lead = LEAD_4;
    end else begin
      c.lead = LEAD_BAD;
    end
    return c;
  endfunction

  // Decodes one code point at the front of w (n bytes valid, n > 0).
  // used = 0 means the sequence is incomplete and must wait for more bytes.
  function automatic dec_t decode(input buf_ent_t [BUF_DEPTH-1:0] w, input logic [2:0] n,
                                  input logic at_end);
    dec_t        d;
    logic [2:0]  len;
    logic        bad;
    logic [15:0] v3;
    logic [20:0] v4;
    d.used = 3'd1;
    d.wide = 1'b0;
    bad    = 1'b0;
    unique case (w[0].cls.lead)
      LEAD_2:  len = 3'd2;
      LEAD_3:  len = 3'd3;
      LEAD_4:  len = 3'd4;
      default: len = 3'd1;
    endcase
    v3 = {w[0].value[3:0], w[1].value[5:0], w[2].value[5:0]};
    v4 = {w[0].value[2:0], w[1].value[5:0], w[2].value[5:0], w[3].value[5:0]};
    if (len > 3'd1) begin
      if (n < len) begin
        if (!at_end) begin
          d.used = 3'd0;
        end
      end else begin
        if (!w[1].cls.cont) bad = 1'b1;
        if (len > 3'd2 && !w[2].cls.cont) bad = 1'b1;
        if (len > 3'd3 && !w[3].cls.cont) bad = 1'b1;
        case (len)
          3'd2: begin
            if (w[0].value[4:1] == 4'd0) bad = 1'b1;
          end
          3'd3: begin
            if (v3 < 16'h0800 || (v3 >= 16'hD800 && v3 <= 16'hDFFF)) bad = 1'b1;
          end
          3'd4: begin
            if (v4 < 21'h10000 || v4 > 21'h10FFFF) bad = 1'b1;
          end
          default: ;
        endcase
        if (!bad) begin
          d.used = len;
          d.wide = (len == 3'd4);
        end
      end
    end
    return d;
  endfunction

endpackage

>>> design/u8c_front.sv
// Front end: accepts input words and tags each byte with its UTF-8 class.
// Depends on u8c_pkg; feeds u8c_queue.
module u8c_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  u8c_pkg::in_item_t  in_data,
  input  logic               q_full,
  output logic               push_valid,
  output u8c_pkg::q_item_t   push_item
);

  assign in_stall   = q_full;
  assign push_valid = in_valid;

  always_comb begin
    push_item.ent.value    = in_data.line_byte;
    push_item.ent.cls      = u8c_pkg::classify(in_data.line_byte);
    push_item.byte_present = in_data.byte_present;
    push_item.last_byte    = in_data.last_byte;
    push_item.mode         = in_data.mode;
    push_item.target       = in_data.target;
  end

endmodule

>>> design/u8c_queue.sv
// Short FIFO between the classifying front end and the decoding back end.
// Depends on u8c_pkg for the entry type.
module u8c_queue #(
  parameter int DEPTH = u8c_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  u8c_pkg::q_item_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output u8c_pkg::q_item_t  head_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u8c_pkg::q_item_t ent_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = ent_r[rd_ptr_r];
  assign push       = push_valid && !full;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> design/u8c_back.sv
// Back end: holds the byte window, decodes one code point per cycle when not
// held by a stalled output, counts code points and UTF-16 units, and registers
// the line result. Depends on u8c_pkg; takes words from u8c_queue.
module u8c_back #(
  parameter int COUNT_WIDTH = u8c_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  u8c_pkg::q_item_t       q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output u8c_pkg::out_item_t     out_data,
  output u8c_pkg::back_status_t  status
);

  localparam int CW   = COUNT_WIDTH;
  localparam int TW   = u8c_pkg::TARGET_WIDTH;
  localparam int CMPW = ((CW > TW) ? CW : TW) + 1;
  localparam int BD   = u8c_pkg::BUF_DEPTH;

  function automatic logic [CW:0] sat_inc(input logic [CW-1:0] a, input logic [1:0] inc);
    logic [CW:0] s;
    s = {1'b0, a} + (CW + 1)'(inc);
    if (s[CW]) begin
      s = {1'b1, {CW{1'b1}}};
    end
    return s;
  endfunction

  u8c_pkg::buf_ent_t [BD-1:0] buf_r, buf_nxt, w_buf;
  logic [2:0]    n_r, w_n, rem;
  logic          mode_r, w_mode;
  logic [TW-1:0] target_r, w_target;
  logic [CW-1:0] unit_r, w_unit, unit_nxt;
  logic [CW-1:0] point_r, w_point, point_nxt;
  logic          reached_r, w_reached, reached_nxt;
  logic          ovf_r, w_ovf, ovf_nxt;
  logic          active_r, last_r, mid_r, w_last;
  logic          out_valid_r;
  u8c_pkg::out_item_t out_data_r, result;

  logic          out_free, go, take, finish, emit, big;
  u8c_pkg::dec_t dec;
  logic [1:0]    inc_u;
  logic [CW:0]   su, sp;
  logic [CW-1:0] count;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign q_pop     = take;
  assign status    = '{active: active_r, mid_line: mid_r};

  always_comb begin
    w_buf     = buf_r;
    w_n       = n_r;
    w_last    = last_r;
    w_mode    = mode_r;
    w_target  = target_r;
    w_unit    = unit_r;
    w_point   = point_r;
    w_reached = reached_r;
    w_ovf     = ovf_r;
    take      = 1'b0;
    go        = 1'b0;
    if (active_r) begin
      // Still rescanning bytes left behind by a replaced lead byte.
      go = !last_r || out_free;
    end else if (q_valid) begin
      go     = !q_head.last_byte || out_free;
      take   = go;
      w_last = q_head.last_byte;
      if (!mid_r) begin
        w_n       = 3'd0;
        w_mode    = q_head.mode;
        w_target  = q_head.target;
        w_unit    = '0;
        w_point   = '0;
        w_reached = 1'b0;
        w_ovf     = 1'b0;
      end
      if (q_head.byte_present) begin
        w_buf[w_n[1:0]] = q_head.ent;
        w_n             = w_n + 3'd1;
      end
    end

    dec = (w_n == 3'd0) ? '0 : u8c_pkg::decode(w_buf, w_n, w_last);

    inc_u       = dec.wide ? 2'd2 : 2'd1;
    su          = sat_inc(w_unit, inc_u);
    sp          = sat_inc(w_point, 2'd1);
    unit_nxt    = w_unit;
    point_nxt   = w_point;
    reached_nxt = w_reached;
    ovf_nxt     = w_ovf;
    if (dec.used != 3'd0 && !w_reached) begin
      if (w_mode == u8c_pkg::MODE_POINTS) begin
        if (CMPW'(w_point) >= CMPW'(w_target)) begin
          reached_nxt = 1'b1;
        end else begin
          unit_nxt  = su[CW-1:0];
          point_nxt = sp[CW-1:0];
          ovf_nxt   = w_ovf | su[CW] | sp[CW];
        end
      end else begin
        // A surrogate pair that would cross the target is not counted.
        if (CMPW'(w_unit) + CMPW'(inc_u) > CMPW'(w_target)) begin
          reached_nxt = 1'b1;
        end else begin
          unit_nxt  = su[CW-1:0];
          point_nxt = sp[CW-1:0];
          ovf_nxt   = w_ovf | su[CW] | sp[CW];
          if (CMPW'(su[CW-1:0]) == CMPW'(w_target)) begin
            reached_nxt = 1'b1;
          end
        end
      end
    end

    buf_nxt = w_buf;
    for (int i = 0; i < BD; i++) begin
      if (i + int'(dec.used) < BD) begin
        buf_nxt[i] = w_buf[2'(i + int'(dec.used))];
      end
    end
    rem    = w_n - dec.used;
    finish = (dec.used == 3'd0) || (rem == 3'd0);
    emit   = go && finish && w_last;

    count           = (w_mode == u8c_pkg::MODE_UNITS) ? point_nxt : unit_nxt;
    big             = CMPW'(count) > CMPW'(17'h0FFFF);
    result.position = big ? 16'hFFFF : 16'(count);
    result.saturated = ovf_nxt | big;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      mode_r      <= 1'b0;
      target_r    <= '0;
      unit_r      <= '0;
      point_r     <= '0;
      reached_r   <= 1'b0;
      ovf_r       <= 1'b0;
      active_r    <= 1'b0;
      last_r      <= 1'b0;
      mid_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        n_r       <= rem;
        mode_r    <= w_mode;
        target_r  <= w_target;
        unit_r    <= unit_nxt;
        point_r   <= point_nxt;
        reached_r <= reached_nxt;
        ovf_r     <= ovf_nxt;
        active_r  <= !finish;
        last_r    <= w_last;
        mid_r     <= !(finish && w_last);
      end
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      buf_r <= buf_nxt;
    end
    if (out_free && emit) begin
      out_data_r <= result;
    end
  end

endmodule

>>> design/utf8_line_utf16_column_convert.sv
// Top level of the UTF-8 line converter between code point and UTF-16 columns.
// Depends on u8c_pkg, u8c_front, u8c_queue and u8c_back.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one word per
//   byte of a text line; byte_present = 0 marks a word with no byte, and
//   last_byte = 1 closes the line. mode and target are taken from the first
//   word of each line. The output channel (out_valid, out_stall, out_data)
//   carries one word per line: the converted column and a saturation flag.
//   Words pass a short queue from the front end to the decoder, so input is
//   taken while a result waits on a stalled output.
//   Throughput is one word per cycle on valid text while the output is not
//   stalled. The decoder handles one code point per cycle, so each further
//   code point decoded from bytes left behind by a replaced lead byte takes a
//   rescan step in which no word is taken. The result is registered and
//   appears on out_valid in the cycle after the last code point is decoded.
//   While out_stall is high the result holds; the decoder then stops only
//   when it reaches the next line end, and the queue fills before in_stall
//   rises. Reset (rst_n low, synchronous) empties the queue, drops any
//   partial line and clears the output; no clearing pass is needed.
module utf8_line_utf16_column_convert #(
  parameter int COUNT_WIDTH = u8c_pkg::COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = u8c_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  u8c_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output u8c_pkg::out_item_t out_data
);

  logic                  push_valid;
  u8c_pkg::q_item_t      push_item;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  u8c_pkg::q_item_t      q_head;
  u8c_pkg::back_status_t status;

  u8c_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  u8c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  u8c_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (status)
  );

  // The decoder only takes a word that the queue holds.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("queue popped while empty");

  // A new word is never taken while the previous one is still being rescanned.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !status.active)
    else $error("queue popped during rescan");

  // Rescanning only happens inside an open line.
  assert property (@(posedge clk) disable iff (!rst_n) status.active |-> status.mid_line)
    else $error("rescan outside a line");

  // A fresh result always means the line was closed.
  assert property (@(posedge clk) disable iff (!rst_n) $rose(out_valid) |-> !status.mid_line)
    else $error("result issued while a line is still open");

endmodule
